### hdl/aph_pkg.sv
// Package with the types, constants and helper functions of the alignment pair histogram.
package aph_pkg;

  localparam int ALPHABET_SIZE = 32;
  localparam int COUNT_WIDTH   = 32;
  localparam int SYM_W         = 5;
  localparam int OUT_W         = 32;
  localparam int TABLE_DEPTH   = ALPHABET_SIZE * (ALPHABET_SIZE + 1) / 2;
  localparam int SLOT_W        = $clog2(TABLE_DEPTH);
  localparam int MQ_DEPTH      = 2;
  localparam int MQ_PTR_W      = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W      = MQ_PTR_W + 1;
  localparam int OQ_DEPTH      = 4;
  localparam int OQ_PTR_W      = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W      = OQ_PTR_W + 1;

  typedef logic [COUNT_WIDTH-1:0] aph_cnt_t;

  typedef enum logic [1:0] {
    KIND_MATCH      = 2'd0,
    KIND_GAP_SECOND = 2'd1,
    KIND_GAP_FIRST  = 2'd2,
    KIND_READ       = 2'd3
  } aph_kind_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SYM_W-1:0] symbol_a;
    logic [SYM_W-1:0] symbol_b;
    logic             alignment_start;
  } aph_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] pair_count;
    logic [OUT_W-1:0] gap_open_count;
    logic [OUT_W-1:0] gap_extend_count;
    logic [OUT_W-1:0] column_count;
  } aph_out_t;

  typedef struct packed {
    aph_kind_t         kind;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
    logic              start;
  } aph_op_t;

  typedef struct packed {
    logic    valid;
    aph_op_t op;
  } aph_opq_t;

  typedef struct packed {
    logic pop;
    logic clear_busy;
  } aph_back_ctl_t;

  function automatic aph_cnt_t sat_inc(input aph_cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic pair_in_range(input logic [SYM_W-1:0] a,
                                         input logic [SYM_W-1:0] b);
    logic [SYM_W:0] hi;
    hi = (a <= b) ? {1'b0, b} : {1'b0, a};
    return hi < (SYM_W + 1)'(ALPHABET_SIZE);
  endfunction

  function automatic logic [SLOT_W-1:0] pair_slot(input logic [SYM_W-1:0] a,
                                                  input logic [SYM_W-1:0] b);
    logic [SYM_W:0]       hi;
    logic [SYM_W:0]       lo;
    logic [2*SYM_W+1:0]   prod;
    logic [2*SYM_W+1:0]   idx;
    hi   = (a <= b) ? {1'b0, b} : {1'b0, a};
    lo   = (a <= b) ? {1'b0, a} : {1'b0, b};
    prod = {{(SYM_W + 1){1'b0}}, hi} * {{(SYM_W + 1){1'b0}}, hi + 1'b1};
    idx  = (prod >> 1) + {{(SYM_W + 1){1'b0}}, lo};
    return idx[SLOT_W-1:0];
  endfunction

endpackage

### hdl/aph_front.sv
// Front end: accepts items, classifies them into table operations and queues them.
module aph_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  aph_pkg::aph_in_t       in_item,
  output aph_pkg::aph_opq_t      opq,
  input  aph_pkg::aph_back_ctl_t back_ctl
);
  import aph_pkg::*;

  aph_op_t             q_r [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] wr_ptr_r;
  logic [MQ_PTR_W-1:0] rd_ptr_r;
  logic [MQ_CNT_W-1:0] cnt_r;
  aph_op_t             op_new;
  logic                accept;
  logic                take;

  always_comb begin
    op_new.kind    = aph_kind_t'(in_item.kind);
    op_new.slot_ok = pair_in_range(in_item.symbol_a, in_item.symbol_b);
    op_new.slot    = pair_slot(in_item.symbol_a, in_item.symbol_b);
    op_new.start   = in_item.alignment_start;
  end

  assign full      = (cnt_r == MQ_CNT_W'(MQ_DEPTH)) || back_ctl.clear_busy;
  assign accept    = push && !full;
  assign take      = back_ctl.pop && (cnt_r != '0);
  assign opq.valid = (cnt_r != '0);
  assign opq.op    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (take) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (accept && !take) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (take && !accept) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) q_r[wr_ptr_r] <= op_new;
  end

endmodule

### hdl/aph_back.sv
// Back end: clears and updates the pair table, keeps the gap and column counters, queues results.
module aph_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  aph_pkg::aph_opq_t      opq,
  output aph_pkg::aph_back_ctl_t back_ctl,
  output logic                   empty,
  input  logic                   pop,
  output aph_pkg::aph_out_t      out_item
);
  import aph_pkg::*;

  aph_cnt_t            pair_mem_r [TABLE_DEPTH];
  aph_cnt_t            mem_q_r;
  aph_op_t             s1_op_r;
  logic                s1_valid_r;
  logic                clr_busy_r;
  logic [SLOT_W-1:0]   clr_addr_r;
  logic                fwd_valid_r;
  logic [SLOT_W-1:0]   fwd_slot_r;
  aph_cnt_t            fwd_data_r;
  logic                jm_r;
  logic                jm_nxt;
  aph_cnt_t            opens_r;
  aph_cnt_t            opens_nxt;
  aph_cnt_t            extends_r;
  aph_cnt_t            extends_nxt;
  aph_cnt_t            cols_r;
  aph_cnt_t            cols_nxt;
  aph_out_t            oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_r;
  logic [OQ_PTR_W-1:0] oq_rd_r;
  logic [OQ_CNT_W-1:0] oq_cnt_r;
  logic                issue;
  logic                oq_take;
  aph_cnt_t            cur;
  aph_cnt_t            inc;
  aph_cnt_t            pc;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  aph_cnt_t            wr_data;
  logic                upd_en;
  aph_out_t            res;

  assign issue = opq.valid && !clr_busy_r &&
                 ((oq_cnt_r + OQ_CNT_W'(s1_valid_r)) < OQ_CNT_W'(OQ_DEPTH));
  assign back_ctl.pop        = issue;
  assign back_ctl.clear_busy = clr_busy_r;
  assign empty    = (oq_cnt_r == '0);
  assign oq_take  = pop && !empty;
  assign out_item = oq_r[oq_rd_r];

  always_comb begin
    cur = (fwd_valid_r && (fwd_slot_r == s1_op_r.slot)) ? fwd_data_r : mem_q_r;
    inc = sat_inc(cur);
    upd_en  = s1_valid_r && (s1_op_r.kind == KIND_MATCH) && s1_op_r.slot_ok;
    wr_en   = clr_busy_r || upd_en;
    wr_addr = clr_busy_r ? clr_addr_r : s1_op_r.slot;
    wr_data = clr_busy_r ? '0 : inc;
    pc = '0;
    if (s1_op_r.slot_ok) begin
      case (s1_op_r.kind)
        KIND_MATCH: pc = inc;
        KIND_READ:  pc = cur;
        default:    pc = '0;
      endcase
    end
    jm_nxt      = jm_r;
    opens_nxt   = opens_r;
    extends_nxt = extends_r;
    cols_nxt    = cols_r;
    if (s1_op_r.kind != KIND_READ) begin
      if (s1_op_r.start) jm_nxt = 1'b0;
      if (s1_op_r.kind == KIND_MATCH) begin
        jm_nxt = 1'b1;
      end else if (jm_nxt) begin
        opens_nxt = sat_inc(opens_r);
        jm_nxt    = 1'b0;
      end else begin
        extends_nxt = sat_inc(extends_r);
      end
      cols_nxt = sat_inc(cols_r);
    end
    res.pair_count       = OUT_W'(pc);
    res.gap_open_count   = OUT_W'(opens_nxt);
    res.gap_extend_count = OUT_W'(extends_nxt);
    res.column_count     = OUT_W'(cols_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      fwd_valid_r <= 1'b0;
      jm_r        <= 1'b0;
      opens_r     <= '0;
      extends_r   <= '0;
      cols_r      <= '0;
      oq_wr_r     <= '0;
      oq_rd_r     <= '0;
      oq_cnt_r    <= '0;
    end else begin
      s1_valid_r  <= issue;
      fwd_valid_r <= upd_en;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == SLOT_W'(TABLE_DEPTH - 1)) clr_busy_r <= 1'b0;
      end
      if (s1_valid_r) begin
        jm_r      <= jm_nxt;
        opens_r   <= opens_nxt;
        extends_r <= extends_nxt;
        cols_r    <= cols_nxt;
        oq_wr_r   <= oq_wr_r + 1'b1;
      end
      if (oq_take) oq_rd_r <= oq_rd_r + 1'b1;
      if (s1_valid_r && !oq_take) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_take && !s1_valid_r) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) pair_mem_r[wr_addr] <= wr_data;
    if (issue) begin
      mem_q_r <= pair_mem_r[opq.op.slot];
      s1_op_r <= opq.op;
    end
    fwd_slot_r <= s1_op_r.slot;
    fwd_data_r <= inc;
    if (s1_valid_r) oq_r[oq_wr_r] <= res;
  end

endmodule

### hdl/alignment_pair_histogram_top.sv
// A result passes the front queue, the stage-one table read register and the output queue before it can pop.
// Throughput: one item per cycle over the single table read and write port, unless the output queue backs up.
// After reset the pair table is cleared, all 528 entries, one entry per cycle,
// with full held high until the sweep is done.
// Reset is synchronous and active low; it clears all counters and queues.
// Top level: connects the classifying front end to the table and counter back end.
module alignment_pair_histogram_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  aph_pkg::aph_in_t  in_item,
  output logic              empty,
  input  logic              pop,
  output aph_pkg::aph_out_t out_item
);
  import aph_pkg::*;

  aph_opq_t      opq;
  aph_back_ctl_t back_ctl;

  aph_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .opq      (opq),
    .back_ctl (back_ctl)
  );

  aph_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .opq      (opq),
    .back_ctl (back_ctl),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

### dv/tb_alignment_pair_histogram_top.sv
`timescale 1ns / 100ps
// Testbench for the alignment pair histogram: directed and random columns checked against a tally.
module tb_alignment_pair_histogram_top;
  import aph_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     push = 1'b0;
  logic     full;
  aph_in_t  in_item = '0;
  logic     empty;
  logic     pop = 1'b0;
  aph_out_t out_item;

  aph_in_t                pending_q[$];
  aph_out_t               expected_q[$];
  logic [COUNT_WIDTH-1:0] pair_tally[TABLE_DEPTH];
  logic                   just_matched;
  logic [COUNT_WIDTH-1:0] gap_opens_seen;
  logic [COUNT_WIDTH-1:0] gap_extends_seen;
  logic [COUNT_WIDTH-1:0] columns_seen;
  int                     n_total;
  int                     n_accepted = 0;
  int                     n_errors = 0;
  int                     hold_left = 0;
  bit                     hold_done = 1'b0;

  alignment_pair_histogram_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  function automatic aph_in_t column_item(input aph_kind_t kind, input int a, input int b,
                                          input bit start);
    aph_in_t it;
    it.kind            = kind;
    it.symbol_a        = SYM_W'(a);
    it.symbol_b        = SYM_W'(b);
    it.alignment_start = start;
    return it;
  endfunction

  task automatic queue_item(input aph_in_t it);
    pending_q.insert(pending_q.size(), it);
  endtask

  function automatic int pick_symbol();
    return ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(31);
  endfunction

  function automatic int pair_index(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b);
    int lo;
    int hi;
    lo = (a <= b) ? int'(a) : int'(b);
    hi = (a <= b) ? int'(b) : int'(a);
    if (hi >= ALPHABET_SIZE) return -1;
    return hi * (hi + 1) / 2 + lo;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic aph_out_t tally_column(input aph_in_t it);
    aph_out_t r;
    int       idx;
    r   = '0;
    idx = pair_index(it.symbol_a, it.symbol_b);
    if (aph_kind_t'(it.kind) == KIND_READ) begin
      if (idx >= 0) r.pair_count = OUT_W'(pair_tally[idx]);
    end else begin
      if (it.alignment_start) just_matched = 1'b0;
      if (aph_kind_t'(it.kind) == KIND_MATCH) begin
        if (idx >= 0) begin
          pair_tally[idx] = bump(pair_tally[idx]);
          r.pair_count = OUT_W'(pair_tally[idx]);
        end
        just_matched = 1'b1;
      end else if (just_matched) begin
        gap_opens_seen = bump(gap_opens_seen);
        just_matched = 1'b0;
      end else begin
        gap_extends_seen = bump(gap_extends_seen);
      end
      columns_seen = bump(columns_seen);
    end
    r.gap_open_count   = OUT_W'(gap_opens_seen);
    r.gap_extend_count = OUT_W'(gap_extends_seen);
    r.column_count     = OUT_W'(columns_seen);
    return r;
  endfunction

  function automatic int phase_now();
    if (n_accepted < n_total / 3) return 0;
    if (n_accepted < 2 * n_total / 3) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (phase_now())
      0: return 34;
      1: return 62;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (phase_now())
      0: return 62;
      1: return 34;
      default: return 0;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
        in_item <= pending_q.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : receiver_hold
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && phase_now() == 2) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  always @(posedge clk) begin : scoreboard
    aph_out_t want;
    if (rst_n && pop && !empty) begin
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("%0t: result with no item pending", $time);
      end else begin
        want = expected_q.pop_front();
        check_field("pair_count", want.pair_count, out_item.pair_count);
        check_field("gap_open_count", want.gap_open_count, out_item.gap_open_count);
        check_field("gap_extend_count", want.gap_extend_count, out_item.gap_extend_count);
        check_field("column_count", want.column_count, out_item.column_count);
      end
    end
    if (rst_n && push && !full) begin
      expected_q.insert(expected_q.size(), tally_column(in_item));
      n_accepted++;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  initial begin
    int len;
    int roll;
    bit in_gap;
    for (int i = 0; i < TABLE_DEPTH; i++) pair_tally[i] = '0;
    just_matched     = 1'b0;
    gap_opens_seen   = '0;
    gap_extends_seen = '0;
    columns_seen     = '0;

    queue_item(column_item(KIND_MATCH, 0, 0, 1'b1));
    queue_item(column_item(KIND_MATCH, 31, 31, 1'b0));
    queue_item(column_item(KIND_MATCH, 31, 0, 1'b0));
    queue_item(column_item(KIND_MATCH, 0, 31, 1'b0));
    queue_item(column_item(KIND_READ, 31, 0, 1'b1));
    queue_item(column_item(KIND_READ, 0, 31, 1'b0));
    queue_item(column_item(KIND_GAP_SECOND, 5, 9, 1'b0));
    queue_item(column_item(KIND_GAP_SECOND, 5, 9, 1'b0));
    queue_item(column_item(KIND_GAP_FIRST, 17, 2, 1'b0));
    queue_item(column_item(KIND_MATCH, 21, 10, 1'b0));
    queue_item(column_item(KIND_GAP_FIRST, 31, 31, 1'b1));
    queue_item(column_item(KIND_MATCH, 10, 21, 1'b1));
    queue_item(column_item(KIND_READ, 21, 10, 1'b1));
    queue_item(column_item(KIND_GAP_FIRST, 0, 0, 1'b0));
    queue_item(column_item(KIND_READ, 7, 3, 1'b0));
    queue_item(column_item(KIND_READ, 0, 0, 1'b0));
    queue_item(column_item(KIND_MATCH, 31, 31, 1'b1));
    queue_item(column_item(KIND_GAP_SECOND, 31, 31, 1'b0));
    queue_item(column_item(KIND_READ, 31, 31, 1'b0));

    while (pending_q.size() < RANDOM_ITEMS + 19) begin
      len    = $urandom_range(30, 4);
      in_gap = 1'b0;
      for (int c = 0; c < len; c++) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          queue_item(column_item(KIND_READ, pick_symbol(), pick_symbol(),
                                 1'($urandom_range(1))));
        end else if (roll < 13) begin
          queue_item(aph_in_t'(($bits(aph_in_t))'($urandom)));
        end else if ((in_gap && roll < 60) || (!in_gap && roll < 40)) begin
          in_gap = 1'b1;
          queue_item(column_item($urandom_range(1) ? KIND_GAP_FIRST : KIND_GAP_SECOND,
                                 $urandom_range(31), $urandom_range(31), c == 0));
        end else begin
          in_gap = 1'b0;
          queue_item(column_item(KIND_MATCH, pick_symbol(), pick_symbol(), c == 0));
        end
      end
    end
    n_total = pending_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (n_accepted < n_total) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
